[rtl/xsharp_pkg.sv]
// Package of the cross sharpening 3x3 filter: register indexes, reset values, divider constants.
package xsharp_pkg;

   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 13;

   typedef logic [CSR_INDEX_WIDTH-1:0] csr_index_type;

   localparam csr_index_type CSR_LINE_WIDTH    = 3'd0;
   localparam csr_index_type CSR_FRAME_HEIGHT  = 3'd1;
   localparam csr_index_type CSR_CENTER_WEIGHT = 3'd2;
   localparam csr_index_type CSR_CROSS_WEIGHT  = 3'd3;
   localparam csr_index_type CSR_INPUT_OFFSET  = 3'd4;
   localparam csr_index_type CSR_OUTPUT_OFFSET = 3'd5;
   localparam csr_index_type CSR_BORDER_VALUE  = 3'd6;

   localparam logic [11:0]        RST_LINE_WIDTH    = 12'd1600;
   localparam logic [12:0]        RST_FRAME_HEIGHT  = 13'd1200;
   localparam logic signed [7:0]  RST_CENTER_WEIGHT = 8'sd10;
   localparam logic signed [7:0]  RST_CROSS_WEIGHT  = -8'sd2;
   localparam logic [7:0]         RST_INPUT_OFFSET  = 8'd0;
   localparam logic [7:0]         RST_OUTPUT_OFFSET = 8'd0;
   localparam logic [7:0]         RST_BORDER_VALUE  = 8'd255;

   // floor(s / 9) = floor((s + 9 * 2^16) * RECIP9 / 2^23) - 2^16 for |s| < 2^19
   localparam logic signed [20:0] SUM_BIAS   = 21'sd589824;
   localparam logic [19:0]        RECIP9     = 20'd932068;
   localparam int                 RECIP_SHIFT = 23;
   localparam logic signed [18:0] QUOT_BIAS  = 19'sd65536;

   localparam logic [7:0]         PIXEL_MAX  = 8'd255;

endpackage

[rtl/cross_sharpen_3x3_filter_top.sv]
// Top level of the cross sharpening 3x3 filter: line memory, window, arithmetic pipeline.
//
// Takes one word per clock on the req_ side while req_stall is low and, once the pipe is full,
// gives one word per clock on the rsp_ side while rsp_stall is low. The
// 3x3 neighbourhood comes from a MAX_WIDTH x 16 line memory (both stored lines in one
// word, one read and one write per clock) and the window registers; the filter sum, the
// divide by nine (reciprocal multiply) and the clamp run in four further register stages.
// The whole pipe advances together, so req_stall follows rsp_stall whenever the output
// register is full. Line memory content after reset is undefined and needs no clearing;
// the first line of a frame is border and never reads it. Pixels per line are clamped to
// 3..MAX_WIDTH and lines per frame to 3..MAX_HEIGHT. Change registers only while idle.
module cross_sharpen_3x3_filter_top #(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic                                   req_kind,
   input  logic [7:0]                             req_pixel,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [7:0]                             rsp_pixel_out,
   output logic                                   rsp_end_of_line,
   output logic                                   rsp_end_of_frame,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [xsharp_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [xsharp_pkg::CSR_DATA_WIDTH-1:0]  csr_data
);
   import xsharp_pkg::*;

   localparam int CW   = $clog2(MAX_WIDTH);
   localparam int WW   = $clog2(MAX_WIDTH + 1);
   localparam int RW   = $clog2(MAX_HEIGHT);
   localparam int HW   = $clog2(MAX_HEIGHT + 1);
   localparam int PW   = $clog2(MAX_WIDTH + 3);
   localparam int LCMP = (WW > 12) ? WW : 12;
   localparam int HCMP = (HW > 13) ? HW : 13;

   // configuration registers
   logic [11:0]       line_width_ff;
   logic [12:0]       frame_height_ff;
   logic signed [7:0] center_weight_ff;
   logic signed [7:0] cross_weight_ff;
   logic [7:0]        input_offset_ff;
   logic [7:0]        output_offset_ff;
   logic [7:0]        border_value_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff    <= RST_LINE_WIDTH;
         frame_height_ff  <= RST_FRAME_HEIGHT;
         center_weight_ff <= RST_CENTER_WEIGHT;
         cross_weight_ff  <= RST_CROSS_WEIGHT;
         input_offset_ff  <= RST_INPUT_OFFSET;
         output_offset_ff <= RST_OUTPUT_OFFSET;
         border_value_ff  <= RST_BORDER_VALUE;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_LINE_WIDTH:    line_width_ff    <= csr_data[11:0];
            CSR_FRAME_HEIGHT:  frame_height_ff  <= csr_data[12:0];
            CSR_CENTER_WEIGHT: center_weight_ff <= csr_data[7:0];
            CSR_CROSS_WEIGHT:  cross_weight_ff  <= csr_data[7:0];
            CSR_INPUT_OFFSET:  input_offset_ff  <= csr_data[7:0];
            CSR_OUTPUT_OFFSET: output_offset_ff <= csr_data[7:0];
            CSR_BORDER_VALUE:  border_value_ff  <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   // effective frame size
   logic [LCMP-1:0] lw_ext;
   logic [HCMP-1:0] fh_ext;
   logic [WW-1:0]   w_eff;
   logic [HW-1:0]   h_eff;

   always_comb begin
      lw_ext = LCMP'(line_width_ff);
      fh_ext = HCMP'(frame_height_ff);
      if (lw_ext < LCMP'(3)) begin
         w_eff = WW'(3);
      end else if (lw_ext > LCMP'(MAX_WIDTH)) begin
         w_eff = WW'(MAX_WIDTH);
      end else begin
         w_eff = lw_ext[WW-1:0];
      end
      if (fh_ext < HCMP'(3)) begin
         h_eff = HW'(3);
      end else if (fh_ext > HCMP'(MAX_HEIGHT)) begin
         h_eff = HW'(MAX_HEIGHT);
      end else begin
         h_eff = fh_ext[HW-1:0];
      end
   end

   // pipe control
   logic adv;
   logic accept;
   logic rsp_valid_ff;

   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;
   assign accept    = req_valid && adv;

   // position counters and pending count
   logic [CW-1:0] in_col_ff, in_col_n, in_col_adv;
   logic [RW-1:0] in_row_ff, in_row_n, in_row_adv;
   logic [CW-1:0] out_col_ff, out_col_n, out_col_adv;
   logic [RW-1:0] out_row_ff, out_row_n, out_row_adv;
   logic [HW-1:0] in_row_t, out_row_t;
   logic          in_wrap, in_col_last, in_row_last;
   logic          out_wrap, out_col_last, out_row_last;
   logic [PW-1:0] pend_ff, pend_in, pend_inc;
   logic          emit;
   logic          border;

   always_comb begin
      in_wrap     = WW'(in_col_ff) >= w_eff;
      in_col_n    = in_wrap ? '0 : in_col_ff;
      in_row_t    = HW'(in_row_ff) + HW'(in_wrap);
      in_row_n    = (in_row_t >= h_eff) ? '0 : in_row_t[RW-1:0];
      in_col_last = (WW'(in_col_n) + WW'(1)) >= w_eff;
      in_row_last = (HW'(in_row_n) + HW'(1)) >= h_eff;
      in_col_adv  = in_col_last ? '0 : in_col_n + CW'(1);
      in_row_adv  = in_col_last ? (in_row_last ? '0 : in_row_n + RW'(1)) : in_row_n;

      out_wrap     = WW'(out_col_ff) >= w_eff;
      out_col_n    = out_wrap ? '0 : out_col_ff;
      out_row_t    = HW'(out_row_ff) + HW'(out_wrap);
      out_row_n    = (out_row_t >= h_eff) ? '0 : out_row_t[RW-1:0];
      out_col_last = (WW'(out_col_n) + WW'(1)) >= w_eff;
      out_row_last = (HW'(out_row_n) + HW'(1)) >= h_eff;
      out_col_adv  = out_col_last ? '0 : out_col_n + CW'(1);
      out_row_adv  = out_col_last ? (out_row_last ? '0 : out_row_n + RW'(1)) : out_row_n;

      border = (out_row_n == '0) || out_row_last || (out_col_n == '0) || out_col_last;

      pend_inc = pend_ff + PW'(1);
      if (req_kind) begin
         emit    = pend_ff != '0;
         pend_in = pend_ff - PW'(emit);
      end else begin
         emit    = pend_inc >= (PW'(w_eff) + PW'(2));
         pend_in = pend_inc - PW'(emit);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
         pend_ff    <= '0;
      end else if (accept) begin
         in_col_ff  <= req_kind ? in_col_n : in_col_adv;
         in_row_ff  <= req_kind ? in_row_n : in_row_adv;
         out_col_ff <= emit ? out_col_adv : out_col_n;
         out_row_ff <= emit ? out_row_adv : out_row_n;
         pend_ff    <= pend_in;
      end
   end

   // stage 1: accepted word, line memory read
   logic [15:0]   line_mem [MAX_WIDTH];
   logic [15:0]   rd_ff;
   logic          s1_valid_ff, s1_emit_ff;
   logic          s1_kind_ff, s1_border_ff, s1_eol_ff, s1_eof_ff;
   logic [7:0]    s1_pixel_ff;
   logic [CW-1:0] s1_col_ff;
   logic          wr_en;

   assign wr_en = adv && s1_valid_ff && !s1_kind_ff;

   always_ff @(posedge clock) begin
      if (accept) begin
         rd_ff <= line_mem[in_col_n];
      end
      if (wr_en) begin
         line_mem[s1_col_ff] <= {rd_ff[7:0], s1_pixel_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s1_emit_ff  <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= req_valid;
         s1_emit_ff  <= req_valid && emit;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_kind_ff   <= req_kind;
         s1_pixel_ff  <= req_pixel;
         s1_col_ff    <= in_col_n;
         s1_border_ff <= border;
         s1_eol_ff    <= out_col_last;
         s1_eof_ff    <= out_col_last && out_row_last;
      end
   end

   // stage 2: window update, tap sums
   logic [7:0] t1_ff, t2_ff, m0_ff, m1_ff, m2_ff, b1_ff, b2_ff;
   logic [7:0] t1_in, t2_in, m0_in, m1_in, m2_in, b1_in, b2_in;
   logic [8:0]  c_sum;
   logic [10:0] x_sum;
   logic [8:0]  s2_c_ff;
   logic [10:0] s2_x_ff;
   logic        s2_emit_ff, s2_border_ff, s2_eol_ff, s2_eof_ff;

   always_comb begin
      if (s1_kind_ff) begin
         t1_in = t1_ff;
         t2_in = t2_ff;
         m0_in = m0_ff;
         m1_in = m1_ff;
         m2_in = m2_ff;
         b1_in = b1_ff;
         b2_in = b2_ff;
      end else begin
         t1_in = t2_ff;
         t2_in = rd_ff[15:8];
         m0_in = m1_ff;
         m1_in = m2_ff;
         m2_in = rd_ff[7:0];
         b1_in = b2_ff;
         b2_in = s1_pixel_ff;
      end
      c_sum = 9'(m1_in) + 9'(input_offset_ff);
      x_sum = 11'(t1_in) + 11'(m0_in) + 11'(m2_in) + 11'(b1_in) + {1'b0, input_offset_ff, 2'b00};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t1_ff <= '0;
         t2_ff <= '0;
         m0_ff <= '0;
         m1_ff <= '0;
         m2_ff <= '0;
         b1_ff <= '0;
         b2_ff <= '0;
      end else if (wr_en) begin
         t1_ff <= t1_in;
         t2_ff <= t2_in;
         m0_ff <= m0_in;
         m1_ff <= m1_in;
         m2_ff <= m2_in;
         b1_ff <= b1_in;
         b2_ff <= b2_in;
      end
   end

   // stage 3: products; stage 4: biased sum; stage 5: quotient
   logic signed [17:0] s3_pc_ff;
   logic signed [19:0] s3_px_ff;
   logic signed [9:0]  c_op;
   logic signed [11:0] x_op;
   logic signed [20:0] sum_b;
   logic [19:0]        s4_n_ff;
   logic [39:0]        quot_prod;
   logic [16:0]        s5_q_ff;
   logic               s3_emit_ff, s3_border_ff, s3_eol_ff, s3_eof_ff;
   logic               s4_emit_ff, s4_border_ff, s4_eol_ff, s4_eof_ff;
   logic               s5_emit_ff, s5_border_ff, s5_eol_ff, s5_eof_ff;

   always_comb begin
      c_op      = $signed({1'b0, s2_c_ff});
      x_op      = $signed({1'b0, s2_x_ff});
      sum_b     = 21'(s3_pc_ff) + 21'(s3_px_ff) + SUM_BIAS;
      quot_prod = 40'(s4_n_ff) * 40'(RECIP9);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_emit_ff <= 1'b0;
         s3_emit_ff <= 1'b0;
         s4_emit_ff <= 1'b0;
         s5_emit_ff <= 1'b0;
      end else if (adv) begin
         s2_emit_ff <= s1_emit_ff;
         s3_emit_ff <= s2_emit_ff;
         s4_emit_ff <= s3_emit_ff;
         s5_emit_ff <= s4_emit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_c_ff      <= c_sum;
         s2_x_ff      <= x_sum;
         s2_border_ff <= s1_border_ff;
         s2_eol_ff    <= s1_eol_ff;
         s2_eof_ff    <= s1_eof_ff;
         s3_pc_ff     <= 18'(center_weight_ff * c_op);
         s3_px_ff     <= 20'(cross_weight_ff * x_op);
         s3_border_ff <= s2_border_ff;
         s3_eol_ff    <= s2_eol_ff;
         s3_eof_ff    <= s2_eof_ff;
         s4_n_ff      <= sum_b[19:0];
         s4_border_ff <= s3_border_ff;
         s4_eol_ff    <= s3_eol_ff;
         s4_eof_ff    <= s3_eof_ff;
         s5_q_ff      <= quot_prod[RECIP_SHIFT+16:RECIP_SHIFT];
         s5_border_ff <= s4_border_ff;
         s5_eol_ff    <= s4_eol_ff;
         s5_eof_ff    <= s4_eof_ff;
      end
   end

   // output register: offset, clamp, border select
   logic signed [18:0] level;
   logic [7:0]         filt;
   logic [7:0]         pixel_out_ff;
   logic               eol_ff, eof_ff;

   always_comb begin
      level = $signed({2'b00, s5_q_ff}) - QUOT_BIAS - $signed({11'd0, output_offset_ff});
      if (level < 0) begin
         filt = '0;
      end else if (level > $signed({11'd0, PIXEL_MAX})) begin
         filt = PIXEL_MAX;
      end else begin
         filt = level[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= s5_emit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pixel_out_ff <= s5_border_ff ? border_value_ff : filt;
         eol_ff       <= s5_eol_ff;
         eof_ff       <= s5_eof_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pixel_out    = pixel_out_ff;
   assign rsp_end_of_line  = eol_ff;
   assign rsp_end_of_frame = eof_ff;

   a_pend_bound: assert property (@(posedge clock) disable iff (reset)
      pend_ff <= PW'(MAX_WIDTH + 2))
      else $error("pending count beyond one line plus two");

   a_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      (wr_en && accept && !req_kind) |-> (in_col_n != s1_col_ff))
      else $error("line memory read and write hit the same column");

   a_flush_empty: assert property (@(posedge clock) disable iff (reset)
      (accept && req_kind && pend_ff == '0) |=> !s1_emit_ff)
      else $error("flush emitted with nothing pending");

   a_eof_eol: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && eof_ff) |-> eol_ff)
      else $error("end of frame without end of line");

endmodule

[tb/tb.sv]
// Testbench of the cross sharpening 3x3 filter: stream driver, result monitor, filter predictor.
`timescale 1ns / 1ps

module tb;
   import xsharp_pkg::*;

   localparam int MAX_W         = 2048;
   localparam int MAX_H         = 4096;
   localparam int RANDOM_PHASES = 16;
   localparam int SETTLE_CYCLES = 12;
   localparam int CYCLE_LIMIT   = 2000000;
   localparam logic KIND_PIXEL  = 1'b0;
   localparam logic KIND_FLUSH  = 1'b1;

   typedef struct packed {
      logic       kind;
      logic [7:0] pixel;
   } word_t;

   typedef struct packed {
      logic [7:0] pixel_out;
      logic       end_of_line;
      logic       end_of_frame;
   } result_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic          req_valid = 1'b0;
   logic          req_stall;
   logic          req_kind = KIND_PIXEL;
   logic [7:0]    req_pixel = 8'd0;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   logic [7:0]    rsp_pixel_out;
   logic          rsp_end_of_line;
   logic          rsp_end_of_frame;
   logic          csr_valid = 1'b0;
   logic          csr_ready;
   csr_index_type csr_index = CSR_LINE_WIDTH;
   logic [CSR_DATA_WIDTH-1:0] csr_data = '0;

   cross_sharpen_3x3_filter_top #(
      .MAX_WIDTH(MAX_W),
      .MAX_HEIGHT(MAX_H)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_kind(req_kind),
      .req_pixel(req_pixel),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_pixel_out(rsp_pixel_out),
      .rsp_end_of_line(rsp_end_of_line),
      .rsp_end_of_frame(rsp_end_of_frame),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   word_t   words_to_send[$];
   result_t expected_pixels[$];
   int      words_queued = 0;
   int      words_accepted = 0;
   int      results_checked = 0;
   int      errors = 0;
   int      cycle_count = 0;
   int      send_idle_pct = 0;
   int      stall_pct = 0;
   int      phases_run = 0;

   // predictor state
   logic [11:0]       cfg_width;
   logic [12:0]       cfg_height;
   logic signed [7:0] cfg_center;
   logic signed [7:0] cfg_cross;
   logic [7:0]        cfg_in_off;
   logic [7:0]        cfg_out_off;
   logic [7:0]        cfg_border;
   logic [7:0]        line_mem [0:2*MAX_W-1];
   logic [7:0]        win [0:2][0:2];
   int unsigned       in_col, in_row, out_col, out_row, pend;

   function automatic int unsigned eff_width();
      if (cfg_width < 3) return 3;
      if (cfg_width > MAX_W) return MAX_W;
      return cfg_width;
   endfunction

   function automatic int unsigned eff_height();
      if (cfg_height < 3) return 3;
      if (cfg_height > MAX_H) return MAX_H;
      return cfg_height;
   endfunction

   function automatic void next_position(inout int unsigned col, inout int unsigned row,
                                         input int unsigned w, input int unsigned h);
      if (col + 1 >= w) begin
         col = 0;
         row = (row + 1 >= h) ? 0 : row + 1;
      end else begin
         col = col + 1;
      end
   endfunction

   function automatic logic [7:0] sharpen_value();
      int center_sum, cross_sum, acc, quo;
      center_sum = int'(win[1][1]) + int'(cfg_in_off);
      cross_sum = int'(win[0][1]) + int'(win[1][0]) + int'(win[1][2]) + int'(win[2][1])
                  + 4 * int'(cfg_in_off);
      acc = int'(cfg_center) * center_sum + int'(cfg_cross) * cross_sum;
      quo = acc / 9;
      if (acc % 9 != 0 && acc < 0) quo = quo - 1;
      quo = quo - int'(cfg_out_off);
      if (quo < 0) quo = 0;
      if (quo > 255) quo = 255;
      return quo[7:0];
   endfunction

   function automatic result_t emit_position(int unsigned w, int unsigned h);
      result_t r;
      logic    last_col, last_row;
      last_col = out_col >= w - 1;
      last_row = out_row >= h - 1;
      if (out_row == 0 || last_row || out_col == 0 || last_col) begin
         r.pixel_out = cfg_border;
      end else begin
         r.pixel_out = sharpen_value();
      end
      r.end_of_line = last_col;
      r.end_of_frame = last_col && last_row;
      next_position(out_col, out_row, w, h);
      pend = pend - 1;
      return r;
   endfunction

   function automatic void filter_step(logic kind, logic [7:0] px);
      int unsigned w, h, col;
      logic [7:0]  top, mid;
      w = eff_width();
      h = eff_height();
      if (in_col >= w) begin
         in_col = 0;
         in_row = in_row + 1;
      end
      if (in_row >= h) in_row = 0;
      if (out_col >= w) begin
         out_col = 0;
         out_row = out_row + 1;
      end
      if (out_row >= h) out_row = 0;
      if (kind == KIND_FLUSH) begin
         if (pend != 0) expected_pixels.push_back(emit_position(w, h));
         return;
      end
      col = in_col;
      top = line_mem[col];
      mid = line_mem[MAX_W + col];
      for (int i = 0; i < 3; i++) begin
         win[i][0] = win[i][1];
         win[i][1] = win[i][2];
      end
      win[0][2] = top;
      win[1][2] = mid;
      win[2][2] = px;
      line_mem[col] = mid;
      line_mem[MAX_W + col] = px;
      next_position(in_col, in_row, w, h);
      if (pend < 32'hFFFF) pend = pend + 1;
      if (pend >= w + 2) expected_pixels.push_back(emit_position(w, h));
   endfunction

   // driver
   always @(posedge clock) begin
      word_t next_word;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            filter_step(req_kind, req_pixel);
            words_accepted = words_accepted + 1;
         end
         if (!req_valid || !req_stall) begin
            if (words_to_send.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               next_word = words_to_send.pop_front();
               req_valid <= 1'b1;
               req_kind <= next_word.kind;
               req_pixel <= next_word.pixel;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      result_t want, got;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_pixel_out, rsp_end_of_line, rsp_end_of_frame};
            if (expected_pixels.size() == 0) begin
               errors = errors + 1;
               if (errors <= 10)
                  $display("unexpected result: pixel %0d eol %0b eof %0b",
                           got.pixel_out, got.end_of_line, got.end_of_frame);
            end else begin
               want = expected_pixels.pop_front();
               if (got !== want) begin
                  errors = errors + 1;
                  if (errors <= 10)
                     $display("result %0d: expected pixel %0d eol %0b eof %0b, got pixel %0d eol %0b eof %0b",
                              results_checked, want.pixel_out, want.end_of_line,
                              want.end_of_frame, got.pixel_out, got.end_of_line,
                              got.end_of_frame);
               end
            end
            results_checked = results_checked + 1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   task automatic push_word(logic kind, logic [7:0] px);
      words_to_send.push_back({kind, px});
      words_queued = words_queued + 1;
   endtask

   task automatic wait_idle();
      while (words_accepted != words_queued || expected_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic drain();
      wait_idle();
      repeat (pend + 1) push_word(KIND_FLUSH, 8'($urandom_range(0, 255)));
      wait_idle();
   endtask

   task automatic write_reg(csr_index_type idx, logic [CSR_DATA_WIDTH-1:0] value);
      @(posedge clock);
      csr_index <= idx;
      csr_data <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_LINE_WIDTH:    cfg_width = value[11:0];
         CSR_FRAME_HEIGHT:  cfg_height = value[12:0];
         CSR_CENTER_WEIGHT: cfg_center = value[7:0];
         CSR_CROSS_WEIGHT:  cfg_cross = value[7:0];
         CSR_INPUT_OFFSET:  cfg_in_off = value[7:0];
         CSR_OUTPUT_OFFSET: cfg_out_off = value[7:0];
         CSR_BORDER_VALUE:  cfg_border = value[7:0];
         default: ;
      endcase
      phases_run = phases_run;
   endtask

   task automatic set_idling(int mode);
      case (mode)
         0: begin send_idle_pct = 0;  stall_pct = 0;  end
         1: begin send_idle_pct = 66; stall_pct = 0;  end
         2: begin send_idle_pct = 0;  stall_pct = 66; end
         default: begin send_idle_pct = 15; stall_pct = 15; end
      endcase
   endtask

   function automatic logic [12:0] pick_width();
      case ($urandom_range(0, 19))
         0: return 13'($urandom_range(0, 2));
         1: return 13'($urandom_range(2049, 4095));
         2: return 13'($urandom_range(13, 64));
         default: return 13'($urandom_range(3, 12));
      endcase
   endfunction

   function automatic logic [12:0] pick_height();
      case ($urandom_range(0, 19))
         0: return 13'd4096;
         1, 2: return 13'($urandom_range(0, 2));
         3, 4: return 13'($urandom_range(9, 8191));
         default: return 13'($urandom_range(3, 8));
      endcase
   endfunction

   function automatic logic [12:0] pick_offset();
      case ($urandom_range(0, 9))
         0: return 13'd0;
         1: return 13'd255;
         2: return 13'd128;
         default: return 13'($urandom_range(0, 255));
      endcase
   endfunction

   initial begin
      int unsigned target, frame_len, style;
      logic [7:0]  base, px;
      int          tmp;
      for (int i = 0; i < 2 * MAX_W; i++) line_mem[i] = 8'd0;
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++) win[i][j] = 8'd0;
      in_col = 0;
      in_row = 0;
      out_col = 0;
      out_row = 0;
      pend = 0;
      cfg_width = RST_LINE_WIDTH;
      cfg_height = RST_FRAME_HEIGHT;
      cfg_center = RST_CENTER_WEIGHT;
      cfg_cross = RST_CROSS_WEIGHT;
      cfg_in_off = RST_INPUT_OFFSET;
      cfg_out_off = RST_OUTPUT_OFFSET;
      cfg_border = RST_BORDER_VALUE;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // full-width frame fills every line store column before any interior read
      set_idling(0);
      write_reg(CSR_LINE_WIDTH, 13'd2048);
      write_reg(CSR_FRAME_HEIGHT, 13'd0);
      repeat (3 * MAX_W) push_word(KIND_PIXEL, 8'($urandom_range(0, 255)));
      drain();
      phases_run = phases_run + 1;

      // smallest frame, weights and offsets at their limits
      write_reg(CSR_LINE_WIDTH, 13'd3);
      write_reg(CSR_FRAME_HEIGHT, 13'd3);
      write_reg(CSR_CENTER_WEIGHT, 13'h07F);
      write_reg(CSR_CROSS_WEIGHT, 13'h080);
      write_reg(CSR_INPUT_OFFSET, 13'd255);
      write_reg(CSR_OUTPUT_OFFSET, 13'd0);
      write_reg(CSR_BORDER_VALUE, 13'd0);
      for (int i = 0; i < 9; i++) push_word(KIND_PIXEL, (i % 2 == 0) ? 8'hFF : 8'h00);
      drain();
      write_reg(CSR_CENTER_WEIGHT, 13'h080);
      write_reg(CSR_CROSS_WEIGHT, 13'h07F);
      write_reg(CSR_OUTPUT_OFFSET, 13'd255);
      write_reg(CSR_BORDER_VALUE, 13'd255);
      // flush ahead of the neighborhood, then finish the frame
      for (int i = 0; i < 5; i++) push_word(KIND_PIXEL, (i % 2 == 0) ? 8'h00 : 8'hFF);
      repeat (5) push_word(KIND_FLUSH, 8'hFF);
      for (int i = 5; i < 9; i++) push_word(KIND_PIXEL, (i % 2 == 0) ? 8'h00 : 8'hFF);
      drain();
      phases_run = phases_run + 1;

      // tallest frame, height written past its maximum
      write_reg(CSR_FRAME_HEIGHT, 13'd8191);
      write_reg(CSR_CENTER_WEIGHT, 13'd10);
      write_reg(CSR_CROSS_WEIGHT, 13'h0FE);
      write_reg(CSR_OUTPUT_OFFSET, 13'd0);
      repeat (3 * MAX_H) push_word(KIND_PIXEL, 8'($urandom_range(0, 255)));
      drain();
      phases_run = phases_run + 1;

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         set_idling(phase % 4);
         write_reg(CSR_LINE_WIDTH, pick_width());
         write_reg(CSR_FRAME_HEIGHT, pick_height());
         write_reg(CSR_CENTER_WEIGHT, 13'($urandom_range(0, 255)));
         write_reg(CSR_CROSS_WEIGHT, 13'($urandom_range(0, 255)));
         write_reg(CSR_INPUT_OFFSET, pick_offset());
         write_reg(CSR_OUTPUT_OFFSET, pick_offset());
         write_reg(CSR_BORDER_VALUE, 13'($urandom_range(0, 255)));
         target = words_queued + $urandom_range(50, 100);
         frame_len = eff_width() * eff_height();
         while (words_queued < target) begin
            style = $urandom_range(0, 2);
            base = 8'($urandom_range(0, 255));
            for (int unsigned p = 0; p < frame_len && words_queued < target; p++) begin
               case (style)
                  0: px = 8'($urandom_range(0, 255));
                  1: px = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                  default: begin
                     tmp = int'(base) + int'($urandom_range(0, 8)) - 4;
                     if (tmp < 0) tmp = 0;
                     if (tmp > 255) tmp = 255;
                     px = tmp[7:0];
                  end
               endcase
               push_word(KIND_PIXEL, px);
               if ($urandom_range(0, 99) < 4)
                  repeat ($urandom_range(1, 3)) push_word(KIND_FLUSH, 8'($urandom_range(0, 255)));
            end
         end
         if ($urandom_range(0, 1)) drain();
         else wait_idle();
         phases_run = phases_run + 1;
      end

      drain();
      errors = errors + expected_pixels.size();
      $display("%0d words driven, %0d results compared over %0d setting phases",
               words_accepted, results_checked, phases_run);
      $display("sizes from 3x3 to 2048 wide and 4096 tall, clamped sizes, extreme weights, early flushes");
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

[cross_sharpen_3x3_filter_top.f]
rtl/xsharp_pkg.sv
rtl/cross_sharpen_3x3_filter_top.sv
tb/tb.sv
